// ===== design/tbp_pkg.sv =====
package tbp_pkg;
  localparam int IDX_BITS = 10;
  localparam int HIST_BITS = 10;
  localparam int DEPTH_BITS = 5;
  localparam int STACK_DEPTH = 16;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_TRAIN_COND = 2'd1;
  localparam logic [1:0] MODE_TRAIN_JUMP = 2'd2;
  localparam logic [1:0] MODE_RECOVER = 2'd3;

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [HIST_BITS-1:0] hist_t;

  // bit0 unconditional, bit1 call, bit2 return
  typedef struct packed {
    logic ret;
    logic call;
    logic uncond;
  } kind_t;

  // saturating 2-bit counter step
  function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction
endpackage

// ===== design/tournament_branch_predictor_unit.sv =====
// A request accepted in idle passes through the lookup and pattern states; the
// result strobe is registered as the pattern state ends. Each request is read, then
// written back, then returned; busy is high while a request is in flight, and no
// new request is taken meanwhile. Reset: a clearing pass over the counter, history
// and BTB valid tables follows reset, with busy high. The receiver cannot stall results.
module tournament_branch_predictor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] pc,
  input  logic        outcome_taken,
  input  logic [31:0] resolved_target,
  input  logic [9:0]  history_in,
  input  logic        jump_is_call,
  input  logic        jump_is_return,
  input  logic [4:0]  stack_depth_in,
  output logic        done,
  output logic        pred_taken,
  output logic [31:0] pred_target,
  output logic        btb_hit,
  output logic        hit_unconditional,
  output logic        hit_call,
  output logic        hit_return,
  output logic [9:0]  history_snapshot,
  output logic [4:0]  stack_depth
);
  import tbp_pkg::*;

  localparam int ENTRIES = 1 << IDX_BITS;
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;
  localparam logic [1:0] ST_PAT = 2'd3;

  logic [1:0] state;
  logic [IDX_BITS:0] clr_cnt;
  logic [1:0] r_mode;
  logic [31:0] r_pc, r_tgt;
  logic r_taken, r_call, r_ret;
  hist_t r_hist;
  logic [DEPTH_BITS-1:0] r_depth;
  hist_t ghist;
  logic [DEPTH_BITS-1:0] rdepth;
  logic [31:0] rstack [STACK_DEPTH];

  // memories
  hist_t lhist_mem [ENTRIES];
  logic [1:0] lcnt_mem [ENTRIES];
  logic [1:0] gcnt_mem [ENTRIES];
  logic [1:0] ccnt_mem [ENTRIES];
  hist_t lhist_q;
  logic [1:0] lcnt_q, gcnt_q, ccnt_q;

  idx_t li, gi;
  hist_t hsel;
  logic clearing;
  assign clearing = (state == ST_CLEAR);
  assign hsel = (mode == MODE_PREDICT) ? ghist : history_in;
  assign li = pc[IDX_BITS+1:2];
  assign gi = pc[IDX_BITS+1:2] ^ hsel;
  idx_t r_li, r_gi;

  logic btb_valid_q;
  logic [31:0] btb_addr_q, btb_tgt_q;
  kind_t btb_kind_q;
  logic btb_we;
  kind_t btb_wkind;
  logic btb_wr_en;
  idx_t btb_wr_idx, btb_rd_idx;

  // hold the BTB read on the captured request while it is in flight
  assign btb_rd_idx = (state == ST_IDLE) ? li : r_li;
  assign btb_wr_en = btb_we || clearing;
  assign btb_wr_idx = clearing ? clr_cnt[IDX_BITS-1:0] : r_li;

  tbp_btb u_btb (
    .clk(clk),
    .rd_idx(btb_rd_idx),
    .rd_valid(btb_valid_q), .rd_address(btb_addr_q),
    .rd_target(btb_tgt_q), .rd_kind(btb_kind_q),
    .wr_en(btb_wr_en), .wr_idx(btb_wr_idx), .wr_valid(!clearing),
    .wr_address(r_pc), .wr_target(r_tgt), .wr_kind(btb_wkind)
  );

  // decode looked-up entry
  logic hit, unc, call, ret, p_loc, p_glb, taken;
  kind_t kind;
  assign hit = btb_valid_q && (btb_addr_q == r_pc);
  assign kind = hit ? btb_kind_q : kind_t'('0);
  assign unc = kind.uncond;
  assign call = kind.call;
  assign ret = kind.ret;
  assign p_loc = lcnt_q[1];
  assign p_glb = gcnt_q[1];
  assign taken = unc ? 1'b1 : (ccnt_q[1] ? (hit && p_glb) : (hit && p_loc));

  assign btb_we = (state == ST_PAT) &&
                  ((r_mode == MODE_TRAIN_COND && r_taken) || r_mode == MODE_TRAIN_JUMP);
  assign btb_wkind = (r_mode == MODE_TRAIN_JUMP) ? kind_t'({r_ret, r_call, 1'b1}) :
                     kind_t'('0);

  // local history, global and chooser tables read at accept
  always_ff @(posedge clk) begin
    if (clearing) begin
      lhist_mem[clr_cnt[IDX_BITS-1:0]] <= '0;
    end else if (state == ST_LOOK && r_mode == MODE_TRAIN_COND) begin
      lhist_mem[r_li] <= {lhist_q[HIST_BITS-2:0], r_taken};
    end
    lhist_q <= lhist_mem[li];
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      gcnt_mem[clr_cnt[IDX_BITS-1:0]] <= '0;
      ccnt_mem[clr_cnt[IDX_BITS-1:0]] <= '0;
    end else if (state == ST_PAT && r_mode == MODE_TRAIN_COND) begin
      gcnt_mem[r_gi] <= sat_move(gcnt_q, r_taken);
      if (p_glb == r_taken && p_loc != r_taken) begin
        ccnt_mem[r_gi] <= sat_move(ccnt_q, 1'b1);
      end else if (p_loc == r_taken && p_glb != r_taken) begin
        ccnt_mem[r_gi] <= sat_move(ccnt_q, 1'b0);
      end
    end
    if (!(state == ST_LOOK)) begin
      gcnt_q <= gcnt_mem[gi];
      ccnt_q <= ccnt_mem[gi];
    end
  end

  // pattern table read with the local history
  idx_t r_gi_l;
  always_ff @(posedge clk) begin
    if (clearing) begin
      lcnt_mem[clr_cnt[IDX_BITS-1:0]] <= '0;
    end else if (state == ST_PAT && r_mode == MODE_TRAIN_COND) begin
      lcnt_mem[r_gi_l] <= sat_move(lcnt_q, r_taken);
    end
    lcnt_q <= lcnt_mem[lhist_q];
  end
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) r_gi_l <= lhist_q;
  end

  // capture request
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      r_mode <= mode;
      r_pc <= pc;
      r_tgt <= resolved_target;
      r_taken <= outcome_taken;
      r_call <= jump_is_call;
      r_ret <= jump_is_return;
      r_hist <= history_in;
      r_depth <= stack_depth_in;
      r_li <= li;
      r_gi <= gi;
    end
  end

  // sequencer, history and stack
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      ghist <= '0;
      rdepth <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + (IDX_BITS+1)'(1);
          if (clr_cnt == (IDX_BITS+1)'(ENTRIES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) state <= ST_LOOK;
        end
        ST_LOOK: state <= ST_PAT;
        ST_PAT: begin
          state <= ST_IDLE;
          done <= 1'b1;
          if (r_mode == MODE_PREDICT && hit) begin
            ghist <= {ghist[HIST_BITS-2:0], (ret || call || unc) ? 1'b1 : taken};
            if (ret) begin
              if (rdepth != '0) rdepth <= rdepth - DEPTH_BITS'(1);
            end else if (call) begin
              if (rdepth < DEPTH_BITS'(STACK_DEPTH)) begin
                rstack[rdepth[3:0]] <= r_pc + 32'd4;
                rdepth <= rdepth + DEPTH_BITS'(1);
              end
            end
          end else if (r_mode == MODE_RECOVER) begin
            ghist <= r_hist;
            rdepth <= (r_depth > DEPTH_BITS'(STACK_DEPTH)) ? DEPTH_BITS'(STACK_DEPTH) : r_depth;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_PAT) begin
      if (r_mode == MODE_PREDICT) begin
        pred_taken <= taken;
        pred_target <= (taken && hit) ? btb_tgt_q : r_pc + 32'd4;
        btb_hit <= hit;
        hit_unconditional <= unc;
        hit_call <= call;
        hit_return <= ret;
        history_snapshot <= ghist;
        stack_depth <= rdepth;
      end else begin
        pred_taken <= 1'b0;
        pred_target <= '0;
        btb_hit <= 1'b0;
        hit_unconditional <= 1'b0;
        hit_call <= 1'b0;
        hit_return <= 1'b0;
        history_snapshot <= '0;
        stack_depth <= '0;
      end
    end
  end

  assign busy = (state != ST_IDLE);
endmodule

// ===== design/tbp_btb.sv =====
module tbp_btb (
  input  logic                 clk,
  input  tbp_pkg::idx_t        rd_idx,
  output logic                 rd_valid,
  output logic [31:0]          rd_address,
  output logic [31:0]          rd_target,
  output tbp_pkg::kind_t       rd_kind,
  input  logic                 wr_en,
  input  tbp_pkg::idx_t        wr_idx,
  input  logic                 wr_valid,
  input  logic [31:0]          wr_address,
  input  logic [31:0]          wr_target,
  input  tbp_pkg::kind_t       wr_kind
);
  import tbp_pkg::*;

  localparam int ENTRIES = 1 << IDX_BITS;

  logic [31:0] address_mem [ENTRIES];
  logic [31:0] target_mem [ENTRIES];
  kind_t kind_mem [ENTRIES];
  logic valid_mem [ENTRIES];

  // store entry fields; the clearing pass writes valid low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      address_mem[wr_idx] <= wr_address;
      target_mem[wr_idx] <= wr_target;
      kind_mem[wr_idx] <= wr_kind;
      valid_mem[wr_idx] <= wr_valid;
    end
    rd_address <= address_mem[rd_idx];
    rd_target <= target_mem[rd_idx];
    rd_kind <= kind_mem[rd_idx];
    rd_valid <= valid_mem[rd_idx];
  end
endmodule

// ===== dv/tournament_branch_predictor_unit_test.sv =====
module tournament_branch_predictor_unit_test;
  import tbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pc;
    logic        taken;
    logic [31:0] target;
    logic [9:0]  hist;
    logic        is_call;
    logic        is_ret;
    logic [4:0]  depth;
  } request_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] target;
    logic        hit;
    logic        uncond;
    logic        call;
    logic        ret;
    logic [9:0]  snap;
    logic [4:0]  depth;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    outcome_t exp;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] mode;
  logic [31:0] pc;
  logic outcome_taken;
  logic [31:0] resolved_target;
  logic [9:0] history_in;
  logic jump_is_call;
  logic jump_is_return;
  logic [4:0] stack_depth_in;
  logic done;
  logic pred_taken;
  logic [31:0] pred_target;
  logic btb_hit;
  logic hit_unconditional;
  logic hit_call;
  logic hit_return;
  logic [9:0] history_snapshot;
  logic [4:0] stack_depth;

  tournament_branch_predictor_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .pc(pc),
    .outcome_taken(outcome_taken), .resolved_target(resolved_target),
    .history_in(history_in), .jump_is_call(jump_is_call),
    .jump_is_return(jump_is_return), .stack_depth_in(stack_depth_in),
    .done(done), .pred_taken(pred_taken), .pred_target(pred_target),
    .btb_hit(btb_hit), .hit_unconditional(hit_unconditional), .hit_call(hit_call),
    .hit_return(hit_return), .history_snapshot(history_snapshot),
    .stack_depth(stack_depth)
  );

  // predictor shadow state
  logic [9:0]  sh_local_hist [1024];
  logic [1:0]  sh_local_ctr [1024];
  logic [1:0]  sh_global_ctr [1024];
  logic [1:0]  sh_chooser [1024];
  logic        sh_btb_valid [1024];
  logic [31:0] sh_btb_addr [1024];
  logic [31:0] sh_btb_target [1024];
  kind_t       sh_btb_kind [1024];
  logic [9:0]  sh_ghist;
  logic [4:0]  sh_depth;

  outcome_t pending_results[$];
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  int predicts = 0;
  int hits = 0;
  logic [9:0] last_snap = '0;
  logic [31:0] pc_pool [16];

  function automatic logic [1:0] step_counter(input logic [1:0] c, input logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  task automatic shadow_reset();
    for (int i = 0; i < 1024; i++) begin
      sh_local_hist[i] = '0;
      sh_local_ctr[i] = '0;
      sh_global_ctr[i] = '0;
      sh_chooser[i] = '0;
      sh_btb_valid[i] = 1'b0;
      sh_btb_addr[i] = '0;
      sh_btb_target[i] = '0;
      sh_btb_kind[i] = '0;
    end
    sh_ghist = '0;
    sh_depth = '0;
  endtask

  // compute the result of one request and advance the shadow state
  task automatic predict_branch(input request_t r, output outcome_t o);
    idx_t li;
    idx_t gi;
    logic [9:0] lh;
    logic hit;
    kind_t k;
    logic tk;
    logic ok_loc;
    logic ok_glb;
    li = r.pc[11:2];
    o = '0;
    case (r.mode)
      MODE_PREDICT: begin
        gi = r.pc[11:2] ^ sh_ghist;
        lh = sh_local_hist[li];
        hit = sh_btb_valid[li] && (sh_btb_addr[li] == r.pc);
        k = hit ? sh_btb_kind[li] : kind_t'(3'b000);
        if (k.uncond) tk = 1'b1;
        else if (sh_chooser[gi] >= 2'd2) tk = hit && (sh_global_ctr[gi] >= 2'd2);
        else tk = hit && (sh_local_ctr[lh] >= 2'd2);
        o.taken = tk;
        o.target = (tk && hit) ? sh_btb_target[li] : r.pc + 32'd4;
        o.hit = hit;
        o.uncond = k.uncond;
        o.call = k.call;
        o.ret = k.ret;
        o.snap = sh_ghist;
        o.depth = sh_depth;
        last_snap = sh_ghist;
        predicts++;
        if (hit) begin
          hits++;
          // return wins over call
          if (k.ret) begin
            if (sh_depth > 0) sh_depth = sh_depth - 5'd1;
          end else if (k.call) begin
            if (sh_depth < STACK_DEPTH) sh_depth = sh_depth + 5'd1;
          end
          sh_ghist = {sh_ghist[8:0], (k.ret || k.call || k.uncond) ? 1'b1 : tk};
        end
      end
      MODE_TRAIN_COND: begin
        gi = r.pc[11:2] ^ r.hist;
        lh = sh_local_hist[li];
        ok_loc = (sh_local_ctr[lh] >= 2'd2) == r.taken;
        ok_glb = (sh_global_ctr[gi] >= 2'd2) == r.taken;
        sh_local_ctr[lh] = step_counter(sh_local_ctr[lh], r.taken);
        sh_local_hist[li] = {lh[8:0], r.taken};
        sh_global_ctr[gi] = step_counter(sh_global_ctr[gi], r.taken);
        if (ok_glb && !ok_loc) sh_chooser[gi] = step_counter(sh_chooser[gi], 1'b1);
        else if (ok_loc && !ok_glb) sh_chooser[gi] = step_counter(sh_chooser[gi], 1'b0);
        if (r.taken) begin
          sh_btb_valid[li] = 1'b1;
          sh_btb_addr[li] = r.pc;
          sh_btb_target[li] = r.target;
          sh_btb_kind[li] = '0;
        end
      end
      MODE_TRAIN_JUMP: begin
        sh_btb_valid[li] = 1'b1;
        sh_btb_addr[li] = r.pc;
        sh_btb_target[li] = r.target;
        sh_btb_kind[li] = '{ret: r.is_ret, call: r.is_call, uncond: 1'b1};
      end
      default: begin
        sh_ghist = r.hist;
        sh_depth = (r.depth > STACK_DEPTH) ? 5'(STACK_DEPTH) : r.depth;
      end
    endcase
  endtask

  function automatic request_t mk_req(input logic [1:0] m, input logic [31:0] p,
                                      input logic t, input logic [31:0] tg,
                                      input logic [9:0] h, input logic c,
                                      input logic rt, input logic [4:0] d);
    return '{mode: m, pc: p, taken: t, target: tg, hist: h, is_call: c,
             is_ret: rt, depth: d};
  endfunction

  function automatic row_t mk_row(input request_t r, input logic fx, input outcome_t e);
    return '{req: r, fixed: fx, exp: e};
  endfunction

  function automatic outcome_t miss_out(input logic [31:0] p, input logic [9:0] h,
                                        input logic [4:0] d);
    return '{taken: 1'b0, target: p + 32'd4, hit: 1'b0, uncond: 1'b0, call: 1'b0,
             ret: 1'b0, snap: h, depth: d};
  endfunction

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && done) begin
      got = '{taken: pred_taken, target: pred_target, hit: btb_hit,
              uncond: hit_unconditional, call: hit_call, ret: hit_return,
              snap: history_snapshot, depth: stack_depth};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result strobe at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: exp tk=%b tgt=%h hit=%b u/c/r=%b%b%b h=%h d=%0d | got tk=%b tgt=%h hit=%b u/c/r=%b%b%b h=%h d=%0d",
                     checked, want.taken, want.target, want.hit, want.uncond, want.call,
                     want.ret, want.snap, want.depth, got.taken, got.target, got.hit,
                     got.uncond, got.call, got.ret, got.snap, got.depth);
        end
      end
    end
  end

  // drive one request and hold it until accepted
  task automatic send_request(input request_t r, input logic fx, input outcome_t e);
    outcome_t o;
    mode = r.mode;
    pc = r.pc;
    outcome_taken = r.taken;
    resolved_target = r.target;
    history_in = r.hist;
    jump_is_call = r.is_call;
    jump_is_return = r.is_ret;
    stack_depth_in = r.depth;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_branch(r, o);
    pending_results.push_back(fx ? e : o);
    @(negedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int sel;
    r.pc = ($urandom_range(0, 9) < 7) ? pc_pool[$urandom_range(0, 15)] : $urandom();
    r.taken = 1'($urandom_range(0, 1));
    r.target = $urandom();
    r.hist = ($urandom_range(0, 1) == 1) ? last_snap : 10'($urandom());
    r.is_call = 1'($urandom_range(0, 1));
    r.is_ret = 1'($urandom_range(0, 1));
    r.depth = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 16));
    sel = $urandom_range(0, 99);
    if (sel < 45) r.mode = MODE_PREDICT;
    else if (sel < 75) r.mode = MODE_TRAIN_COND;
    else if (sel < 90) r.mode = MODE_TRAIN_JUMP;
    else r.mode = MODE_RECOVER;
    return r;
  endfunction

  row_t directed [20];

  initial begin
    int sent;
    int burst;
    int gap;
    outcome_t z;
    z = '0;
    start = 1'b0;
    mode = MODE_PREDICT;
    pc = '0;
    outcome_taken = 1'b0;
    resolved_target = '0;
    history_in = '0;
    jump_is_call = 1'b0;
    jump_is_return = 1'b0;
    stack_depth_in = '0;
    rst = 1'b1;
    shadow_reset();
    for (int i = 0; i < 16; i++)
      pc_pool[i] = (i < 12) ? {18'($urandom()), 12'($urandom()) & 12'hffc, 2'b00}
                            : $urandom();

    // directed rows: fixed expectations where obvious, else the predictor
    directed[0] = mk_row(mk_req(MODE_PREDICT, 32'h0, '0, '0, '0, '0, '0, '0), 1'b1,
                         miss_out(32'h0, '0, '0));
    directed[1] = mk_row(mk_req(MODE_PREDICT, 32'hffff_fffc, 1'b1, '1, '1, 1'b1, 1'b1, '1),
                         1'b1, miss_out(32'hffff_fffc, '0, '0));
    directed[2] = mk_row(mk_req(MODE_TRAIN_COND, 32'h40, 1'b1, 32'h1000, '0, '0, '0, '0),
                         1'b1, z);
    directed[3] = mk_row(mk_req(MODE_PREDICT, 32'h40, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[4] = mk_row(mk_req(MODE_TRAIN_JUMP, 32'h80, '0, 32'h2000, '0, 1'b1, '0, '0),
                         1'b1, z);
    directed[5] = mk_row(mk_req(MODE_PREDICT, 32'h80, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[6] = mk_row(mk_req(MODE_TRAIN_JUMP, 32'hc0, '0, 32'h3000, '0, 1'b1, 1'b1, '0),
                         1'b1, z);
    directed[7] = mk_row(mk_req(MODE_PREDICT, 32'hc0, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[8] = mk_row(mk_req(MODE_PREDICT, 32'hc0, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[9] = mk_row(mk_req(MODE_TRAIN_JUMP, 32'h84, 1'b1, 32'h4000, '0, '0, 1'b1, '0),
                         1'b1, z);
    directed[10] = mk_row(mk_req(MODE_PREDICT, 32'h84, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[11] = mk_row(mk_req(MODE_RECOVER, 32'h0, '0, '0, '1, '0, '0, 5'd31), 1'b1, z);
    directed[12] = mk_row(mk_req(MODE_PREDICT, 32'h10, '0, '0, '0, '0, '0, '0), 1'b1,
                          miss_out(32'h10, '1, 5'd16));
    directed[13] = mk_row(mk_req(MODE_PREDICT, 32'h80, '0, '0, '0, '0, '0, '0), 1'b0, z);
    directed[14] = mk_row(mk_req(MODE_RECOVER, 32'h0, 1'b1, '0, '0, 1'b1, 1'b1, 5'd16),
                          1'b1, z);
    directed[15] = mk_row(mk_req(MODE_TRAIN_COND, 32'hffff_fffc, '0, '0, '1, '0, '0, '0),
                          1'b1, z);
    directed[16] = mk_row(mk_req(MODE_TRAIN_COND, 32'hffff_fffc, 1'b1, '1, '1, '0, '0, '0),
                          1'b1, z);
    directed[17] = mk_row(mk_req(MODE_PREDICT, 32'hffff_fffc, '0, '0, '0, '0, '0, '0),
                          1'b0, z);
    directed[18] = mk_row(mk_req(MODE_RECOVER, '1, '0, '1, '0, '0, '0, 5'd0), 1'b1, z);
    directed[19] = mk_row(mk_req(MODE_PREDICT, 32'h40, '0, '0, '0, '0, '0, '0), 1'b0, z);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_request(directed[i].req, directed[i].fixed, directed[i].exp);
    start = 1'b0;

    // random traffic in bursts
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_request(random_request(), 1'b0, z);
        sent++;
        if (sent == RANDOM_ITEMS / 2) begin
          // hold until the pipeline drains
          start = 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
      start = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    start = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d results over %0d requests; %0d predictions, %0d BTB hits",
             checked, sent + 20, predicts, hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/tbp_pkg.sv
design/tbp_btb.sv
design/tournament_branch_predictor_unit.sv
dv/tournament_branch_predictor_unit_test.sv
